@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros used by prefix_function_stream
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, quiet while rst_ni is low
`define CHK_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("check failed");

// same check with a caller supplied message string
`define CHK_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

@@ hdl/kmp_pkg.sv @@
// ---------------------------------------------------------------------------
// kmp_pkg
// constants and types of the streaming prefix function block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

  // string capacity in symbols
  localparam int unsigned MaxLen   = 1024;
  localparam int unsigned AddrW    = $clog2(MaxLen);
  localparam int unsigned PosW     = AddrW + 1;
  localparam int unsigned SymW     = 8;
  localparam int unsigned LenW     = 10;
  localparam int unsigned InDataW  = ((SymW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((LenW + 7) / 8) * 8;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [PosW-1:0]  pos_t;
  typedef logic [SymW-1:0]  sym_t;
  typedef logic [LenW-1:0]  len_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_e;

endpackage

`default_nettype wire

@@ hdl/kmp_ram.sv @@
// ---------------------------------------------------------------------------
// kmp_ram
// generic simple dual port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kmp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/prefix_function_stream.sv @@
// sequence: an accepted word goes to S_READ, which takes one fallback step per mismatch until
//   the border is settled, then to S_EMIT; a first or overflowed word goes straight to S_EMIT
// flow: a new word is accepted only in S_IDLE, after S_EMIT has loaded the previous result,
//   which waits while the output is stalled; fallback steps sum to at most the string length
// reset: rst_ni clears position, last border, overflow flag and output valid; the
//   symbol and border rams need no clearing since only written entries are read
// ---------------------------------------------------------------------------
// prefix_function_stream
// streaming knuth-morris-pratt prefix function over byte symbols
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module prefix_function_stream (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [kmp_pkg::InDataW-1:0]   s_axis_tdata,  // [7:0] symbol
  input  wire logic                          s_axis_tuser,  // [0] start_req
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [kmp_pkg::OutDataW-1:0]  m_axis_tdata,  // [9:0] prefix_len
  output logic                               m_axis_tuser   // [0] overflow
);

  import kmp_pkg::*;

  state_e state_q, state_d;
  sym_t   sym_q, sym_d;
  addr_t  j_q, j_d;
  addr_t  len_q, len_d;
  addr_t  lb_q, lb_d;
  pos_t   pos_q, pos_d;
  logic   ovf_q, ovf_d;
  logic   m_valid_q, m_valid_d;
  len_t   m_len_q, m_len_d;
  logic   m_ovf_q, m_ovf_d;

  // ram ports
  logic  wr_en;
  addr_t sym_raddr, brd_raddr;
  sym_t  sym_rdata;
  addr_t brd_rdata;

  // accept side helpers
  logic  accept, start;
  pos_t  pos_eff;
  addr_t lb_eff, j_start;
  logic  ovf_eff, ovf_new;
  logic  emit_ok;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign start   = s_axis_tuser;
  assign pos_eff = start ? '0 : pos_q;
  assign lb_eff  = start ? '0 : lb_q;
  assign ovf_eff = start ? 1'b0 : ovf_q;
  assign ovf_new = ovf_eff || (pos_eff >= PosW'(MaxLen));
  assign j_start = (PosW'(lb_eff) >= pos_eff) ? '0 : lb_eff;
  assign emit_ok = !m_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign wr_en         = (state_q == S_EMIT) && emit_ok && !ovf_q;

  always_comb begin
    state_d   = state_q;
    sym_d     = sym_q;
    j_d       = j_q;
    len_d     = len_q;
    lb_d      = lb_q;
    pos_d     = pos_q;
    ovf_d     = ovf_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_len_d   = m_len_q;
    m_ovf_d   = m_ovf_q;
    sym_raddr = brd_rdata;
    brd_raddr = brd_rdata - AddrW'(1);

    case (state_q)
      S_IDLE: begin
        sym_raddr = j_start;
        brd_raddr = j_start - AddrW'(1);
        if (accept) begin
          sym_d = s_axis_tdata[SymW-1:0];
          pos_d = pos_eff;
          lb_d  = lb_eff;
          ovf_d = ovf_new;
          j_d   = j_start;
          len_d = '0;
          // first symbol of a string or overflowed: result is known now
          if (ovf_new || (pos_eff == '0)) begin
            state_d = S_EMIT;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        if (sym_rdata == sym_q) begin
          len_d   = j_q + AddrW'(1);
          state_d = S_EMIT;
        end else if (j_q == '0) begin
          len_d   = '0;
          state_d = S_EMIT;
        end else begin
          // fall back to the border of the shorter prefix
          j_d = brd_rdata;
        end
      end
      S_EMIT: begin
        if (emit_ok) begin
          m_valid_d = 1'b1;
          m_len_d   = ovf_q ? '0 : LenW'(len_q);
          m_ovf_d   = ovf_q;
          if (!ovf_q) begin
            pos_d = pos_q + PosW'(1);
            lb_d  = len_q;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pos_q     <= '0;
      lb_q      <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      lb_q      <= lb_d;
      ovf_q     <= ovf_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q   <= sym_d;
    j_q     <= j_d;
    len_q   <= len_d;
    m_len_q <= m_len_d;
    m_ovf_q <= m_ovf_d;
  end

  kmp_ram #(
    .Width (SymW),
    .Depth (MaxLen)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (pos_q[AddrW-1:0]),
    .wdata_i (sym_q),
    .raddr_i (sym_raddr),
    .rdata_o (sym_rdata)
  );

  kmp_ram #(
    .Width (AddrW),
    .Depth (MaxLen)
  ) u_brd_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (pos_q[AddrW-1:0]),
    .wdata_i (len_q),
    .raddr_i (brd_raddr),
    .rdata_o (brd_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutDataW'(m_len_q);
  assign m_axis_tuser  = m_ovf_q;

  `CHK_ASSERT(a_pos_bound, pos_q <= PosW'(MaxLen))
  `CHK_ASSERT_MSG(a_border_below_pos, (pos_q != '0) |-> (PosW'(lb_q) < pos_q),
    "last border not below position")
  `CHK_ASSERT_MSG(a_fallback_in_range, (state_q == S_READ) |-> (PosW'(j_q) < pos_q),
    "fallback index outside written entries")
  `CHK_ASSERT(a_emit_loads_output,
    ((state_q == S_EMIT) && emit_ok) |=> (m_valid_q && (state_q == S_IDLE)))

endmodule

`default_nettype wire
